### hdl/cmykrgb_pkg.sv
// cmykrgb_pkg: shared constants and the per-stage data type of the
// CMYK/RGB converter pipeline. No dependencies.
`default_nettype none

package cmykrgb_pkg;

    localparam int CH_W      = 8;
    localparam int WORD_W    = 32;
    localparam int NUM_LANES = 3;
    localparam int LANE_W    = 2 * CH_W;
    // one restoring-division step per cell, one quotient bit each
    localparam int NUM_CELLS = CH_W;

    localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

    typedef enum logic {
        OP_CMYK_TO_RGB = 1'b0,
        OP_RGB_TO_CMYK = 1'b1
    } t_op;

    // lane: {partial remainder, dividend bits not yet used / quotient bits}
    typedef struct packed {
        t_op                                  op;
        logic [CH_W-1:0]                      key_k;
        logic [CH_W-1:0]                      den;
        logic [NUM_LANES-1:0][LANE_W-1:0]     lane;
    } t_cell_data;

endpackage

`default_nettype wire

### hdl/cmykrgb_prep.sv
// cmykrgb_prep: first cell of the chain; forms the per-channel dividends and one shared
// divisor for either direction. Depends on cmykrgb_pkg.
`default_nettype none

module cmykrgb_prep (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    input  wire                            i_operation,
    input  wire [cmykrgb_pkg::WORD_W-1:0]  i_color_word,
    input  wire                            i_hold,
    output logic                           o_hold,
    output logic                           o_valid,
    output cmykrgb_pkg::t_cell_data        o_data
);
    import cmykrgb_pkg::*;

    logic                               r_valid;
    t_cell_data                         r_data;
    t_cell_data                         n_data;

    logic [NUM_LANES-1:0][CH_W-1:0]     chan;
    logic [NUM_LANES-1:0][CH_W-1:0]     inv;
    logic [NUM_LANES-1:0][CH_W-1:0]     diff;
    logic [CH_W-1:0]                    kinv;
    logic [CH_W-1:0]                    kmin;

    always_comb begin
        // lane 0 is the most significant color byte of the result
        for (int l = 0; l < NUM_LANES; l++) begin
            // R, G, B sit one byte lower than C, M, Y
            if (i_operation == OP_RGB_TO_CMYK) begin
                chan[l] = i_color_word[(NUM_LANES - 1 - l) * CH_W +: CH_W];
            end else begin
                chan[l] = i_color_word[(NUM_LANES - l) * CH_W +: CH_W];
            end
            inv[l]  = CH_MAX - chan[l];
        end
        kinv = CH_MAX - i_color_word[CH_W-1:0];

        kmin = inv[0];
        if (inv[1] < kmin) kmin = inv[1];
        if (inv[2] < kmin) kmin = inv[2];

        for (int l = 0; l < NUM_LANES; l++) begin
            diff[l] = inv[l] - kmin;
        end

        n_data.op = t_op'(i_operation);
        if (i_operation == OP_RGB_TO_CMYK) begin
            n_data.key_k = kmin;
            // black: dividends are zero, a divisor of one gives zero inks
            n_data.den   = (kmin == CH_MAX) ? CH_W'(1) : (CH_MAX - kmin);
            for (int l = 0; l < NUM_LANES; l++) begin
                n_data.lane[l] = {diff[l], {CH_W{1'b0}}} - {{CH_W{1'b0}}, diff[l]};
            end
        end else begin
            n_data.key_k = i_color_word[CH_W-1:0];
            n_data.den   = CH_MAX;
            for (int l = 0; l < NUM_LANES; l++) begin
                n_data.lane[l] = {{CH_W{1'b0}}, inv[l]} * {{CH_W{1'b0}}, kinv};
            end
        end
    end

    assign o_hold = r_valid && i_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_hold) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_hold) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

### hdl/cmykrgb_div_cell.sv
// cmykrgb_div_cell: one restoring-division step on all three lanes,
// yielding one quotient bit per lane. Depends on cmykrgb_pkg.
`default_nettype none

module cmykrgb_div_cell (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  cmykrgb_pkg::t_cell_data      i_data,
    input  wire                          i_hold,
    output logic                         o_hold,
    output logic                         o_valid,
    output cmykrgb_pkg::t_cell_data      o_data
);
    import cmykrgb_pkg::*;

    logic                               r_valid;
    t_cell_data                         r_data;
    t_cell_data                         n_data;

    logic [NUM_LANES-1:0][CH_W:0]       trial;
    logic [NUM_LANES-1:0][CH_W:0]       sub;
    logic [NUM_LANES-1:0][CH_W-1:0]     rem;
    logic [NUM_LANES-1:0]               qbit;

    always_comb begin
        n_data = i_data;
        for (int l = 0; l < NUM_LANES; l++) begin
            trial[l] = {i_data.lane[l][LANE_W-1:CH_W], i_data.lane[l][CH_W-1]};
            sub[l]   = trial[l] - {1'b0, i_data.den};
            qbit[l]  = (trial[l] >= {1'b0, i_data.den});
            rem[l]   = qbit[l] ? sub[l][CH_W-1:0] : trial[l][CH_W-1:0];
            n_data.lane[l] = {rem[l], i_data.lane[l][CH_W-2:0], qbit[l]};
        end
    end

    assign o_hold = r_valid && i_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_hold) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_hold) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

### hdl/cmyk_rgb_color_converter_core.sv
// cmyk_rgb_color_converter_core: CMYK <-> RGB converter, 8 bits per channel.
// Pipeline: 1 prep cell and 8 divide cells, each registered, from input to output valid.
// Throughput: one transaction per cycle unless stalled; each cell holds one item and
// bubbles collapse, so input is still taken on an output stall while a cell is empty.
// Reset: synchronous, active low; clears all cell valid bits, data is not reset.
// Depends on cmykrgb_pkg, cmykrgb_prep, cmykrgb_div_cell.
`default_nettype none

module cmyk_rgb_color_converter_core (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_stall,
    input  wire                            i_operation,
    input  wire [cmykrgb_pkg::WORD_W-1:0]  i_color_word,
    output logic                           o_valid,
    input  wire                            i_stall,
    output logic [cmykrgb_pkg::WORD_W-1:0] o_result_word
);
    import cmykrgb_pkg::*;

    logic       [NUM_CELLS:0]   valid_chain;
    logic       [NUM_CELLS+1:0] hold_chain;
    t_cell_data                 data_chain [NUM_CELLS+1];
    t_cell_data                 last;

    cmykrgb_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_operation  (i_operation),
        .i_color_word (i_color_word),
        .i_hold       (hold_chain[1]),
        .o_hold       (hold_chain[0]),
        .o_valid      (valid_chain[0]),
        .o_data       (data_chain[0])
    );

    // the top of the hold chain is the output stall
    assign hold_chain[NUM_CELLS+1] = i_stall;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        cmykrgb_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid_chain[g]),
            .i_data  (data_chain[g]),
            .i_hold  (hold_chain[g+2]),
            .o_hold  (hold_chain[g+1]),
            .o_valid (valid_chain[g+1]),
            .o_data  (data_chain[g+1])
        );
    end

    assign last    = data_chain[NUM_CELLS];
    assign o_valid = valid_chain[NUM_CELLS];
    assign o_stall = hold_chain[0];

    always_comb begin
        if (last.op == OP_RGB_TO_CMYK) begin
            o_result_word = {last.lane[0][CH_W-1:0], last.lane[1][CH_W-1:0],
                             last.lane[2][CH_W-1:0], last.key_k};
        end else begin
            o_result_word = {{CH_W{1'b0}}, last.lane[0][CH_W-1:0],
                             last.lane[1][CH_W-1:0], last.lane[2][CH_W-1:0]};
        end
    end

    // input back-pressure only ever comes from output back-pressure
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> i_stall)
        else $error("input stalled without output stall");

    // black pixel: no ink besides K
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && last.op == OP_RGB_TO_CMYK && last.key_k == CH_MAX)
            |-> (o_result_word[WORD_W-1:CH_W] == '0))
        else $error("black pixel produced nonzero C/M/Y");

    // the channel that sets K always yields zero ink
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && last.op == OP_RGB_TO_CMYK)
            |-> (o_result_word[31:24] == '0 || o_result_word[23:16] == '0 ||
                 o_result_word[15:8] == '0))
        else $error("no C/M/Y channel is zero");

    // valid bits come out of reset clear
    assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire
